[src/hdd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hierarchy divergence depth block.
// No dependencies; imported by hdd_bins and hierarchy_divergence_depth.
package hdd_pkg;

    typedef enum logic [1:0] {
        MODE_WR_ANC   = 2'd0,
        MODE_WR_DEPTH = 2'd1,
        MODE_PAIR     = 2'd2,
        MODE_HIST     = 2'd3
    } mode_t;

    localparam logic [1:0] CFG_NUM_LEAVES = 2'd0;
    localparam logic [1:0] CFG_NUM_TIERS  = 2'd1;

    typedef struct packed {
        logic capture_z;
        logic clear;
        logic count;
        logic shift;
    } bins_ctrl_t;

    function automatic logic [4:0] sat_depth(input logic [3:0] d, input logic [4:0] t);
        logic [4:0] r;
        begin
            r = {1'b0, d};
            if (r == 5'd0)
            begin
                r = 5'd1;
            end
            if (r > t)
            begin
                r = t;
            end
            return r;
        end
    endfunction

endpackage

[src/hdd_table.sv]
`timescale 1ns / 1ps
// Ancestor row memory and leaf depth memory, one synchronous read port each.
// Depends on nothing; instantiated by hierarchy_divergence_depth.
module hdd_table #(
    parameter int MAX_LEAVES = 64,
    parameter int MAX_TIERS  = 8
) (
    input  logic                                 clk,
    input  logic                                 wr_anc_en,
    input  logic                                 wr_depth_en,
    input  logic [5:0]                           wr_leaf,
    input  logic [2:0]                           wr_tier,
    input  logic [6:0]                           wr_ancestor,
    input  logic [3:0]                           wr_depth,
    input  logic                                 rd_en,
    input  logic [5:0]                           rd_leaf_in,
    output logic [5:0]                           rd_leaf,
    output logic                                 rd_oor,
    output logic [MAX_TIERS-2:0][6:0]            rd_row,
    output logic [3:0]                           rd_depth
);
    localparam int ROW = MAX_TIERS - 1;
    localparam int LW  = $clog2(MAX_LEAVES);
    localparam int RW  = (ROW > 1) ? $clog2(ROW) : 1;

    logic [ROW-1:0][6:0] anc_mem [MAX_LEAVES];
    logic [3:0]          depth_mem [MAX_LEAVES];

    logic          wr_leaf_ok;
    logic          wr_tier_ok;
    logic          rd_leaf_ok;
    logic [LW-1:0] wr_addr;
    logic [LW-1:0] rd_addr;
    logic [RW-1:0] wr_col;

    assign wr_leaf_ok = {1'b0, wr_leaf} < 7'(MAX_LEAVES);
    assign rd_leaf_ok = {1'b0, rd_leaf_in} < 7'(MAX_LEAVES);
    assign wr_tier_ok = int'(wr_tier) < ROW;
    assign wr_addr    = LW'(wr_leaf);
    assign rd_addr    = LW'(rd_leaf_in);
    assign wr_col     = RW'(wr_tier);

    // Writes are only taken while the sequencer is idle, so a write never
    // meets a read of the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (wr_anc_en && wr_leaf_ok && wr_tier_ok)
        begin
            anc_mem[wr_addr][wr_col] <= wr_ancestor;
        end
        if (wr_depth_en && wr_leaf_ok)
        begin
            depth_mem[wr_addr] <= wr_depth;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row   <= anc_mem[rd_addr];
            rd_depth <= depth_mem[rd_addr];
            rd_leaf  <= rd_leaf_in;
            rd_oor   <= !rd_leaf_ok;
        end
    end

endmodule

[src/hdd_bins.sv]
`timescale 1ns / 1ps
// Tier compare of one row against the query leaf, and the histogram counters.
// Depends on hdd_pkg; instantiated by hierarchy_divergence_depth.
module hdd_bins #(
    parameter int MAX_TIERS = 8
) (
    input  logic                                  clk,
    input  hdd_pkg::bins_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_TIERS+1)-1:0]        t,
    input  logic [5:0]                            rd_leaf,
    input  logic                                  rd_oor,
    input  logic [MAX_TIERS-2:0][6:0]             rd_row,
    input  logic [3:0]                            rd_depth,
    input  logic                                  mask_bit,
    output logic [6:0]                            cnt_head,
    output logic [6:0]                            pair_value
);
    import hdd_pkg::*;

    localparam int ROW = MAX_TIERS - 1;
    localparam int TW  = $clog2(MAX_TIERS + 1);

    logic [ROW-1:0][6:0] z_step_reg;
    logic [5:0]          z_leaf_reg;
    logic [TW-1:0]       z_depth_reg;
    logic [6:0]          cnt_reg [MAX_TIERS+1];

    logic [ROW-1:0][6:0] cur_step;
    logic [TW-1:0]       cur_depth;
    logic [TW-1:0]       mismatch;
    logic [TW-1:0]       bin_sel;
    logic                same;
    logic                hit;

    always_comb
    begin
        cur_depth = TW'(sat_depth(rd_oor ? 4'd0 : rd_depth, 5'(t)));
        for (int h = 0; h < ROW; h++)
        begin
            if (h + 1 == int'(cur_depth))
            begin
                cur_step[h] = {1'b0, rd_leaf};
            end
            else
            begin
                cur_step[h] = rd_oor ? 7'd0 : rd_row[h];
            end
        end
        mismatch = z_depth_reg - TW'(1);
        for (int h = ROW - 1; h >= 0; h--)
        begin
            if ((h < int'(z_depth_reg) - 1) && (cur_step[h] != z_step_reg[h]))
            begin
                mismatch = TW'(h);
            end
        end
        same       = (rd_leaf == z_leaf_reg);
        bin_sel    = same ? z_depth_reg : mismatch;
        hit        = ctrl.count && (same || mask_bit);
        pair_value = same ? 7'(z_depth_reg) : 7'(mismatch);
    end

    assign cnt_head = cnt_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.capture_z)
        begin
            z_step_reg  <= cur_step;
            z_depth_reg <= cur_depth;
            z_leaf_reg  <= rd_leaf;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= MAX_TIERS; i++)
        begin
            if (ctrl.clear)
            begin
                cnt_reg[i] <= 7'd0;
            end
            else if (ctrl.shift)
            begin
                if (i < MAX_TIERS)
                begin
                    cnt_reg[i] <= cnt_reg[(i < MAX_TIERS) ? i + 1 : i];
                end
                else
                begin
                    cnt_reg[i] <= 7'd0;
                end
            end
            else if (hit && (bin_sel == TW'(i)))
            begin
                cnt_reg[i] <= cnt_reg[i] + 7'd1;
            end
        end
    end

endmodule

[src/hierarchy_divergence_depth.sv]
`timescale 1ns / 1ps
// Top level: sequencer, configuration registers and output register.
// Depends on hdd_pkg, hdd_table and hdd_bins.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  config  | in        | cfg_write_en         | cfg_index, cfg_data
//  request | in        | in_valid / in_ready  | mode, leaf, other_leaf, tier, ancestor,
//          |           |                      | depth, prior_mask
//  result  | out       | out_valid / out_ready| bin, value, last
//
// A write request is taken while idle and leaves the sequencer idle. A pair query reads the
// query leaf, then the other leaf, and registers the result. A histogram query walks the table,
// one leaf row a cycle through the single read port over the N leaves in use, then emits
// num_tiers + 1 bins, one bin a cycle while the result is not stalled.
// Reset clears the sequencer and sets the configuration registers to 64 leaves and 8 tiers; the tables need no sweep.
// A stalled result holds the output register and pauses the bin emission.
module hierarchy_divergence_depth #(
    parameter int MAX_LEAVES = 64,
    parameter int MAX_TIERS  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [5:0]        leaf,
    input  logic [5:0]        other_leaf,
    input  logic [2:0]        tier,
    input  logic signed [6:0] ancestor,
    input  logic [3:0]        depth,
    input  logic [63:0]       prior_mask,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        bin,
    output logic [6:0]        value,
    output logic              last
);
    import hdd_pkg::*;

    localparam int LW = $clog2(MAX_LEAVES);
    localparam int TW = $clog2(MAX_TIERS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CAPZ = 5'b00010,
        S_PAIR = 5'b00100,
        S_WALK = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [6:0]            leaf_count_reg;
    logic [3:0]            num_tiers_reg;
    logic                  hist_reg, hist_next;
    logic [5:0]            other_reg, other_next;
    logic [MAX_LEAVES-1:0] mask_reg, mask_next;
    logic [LW:0]           issue_k_reg, issue_k_next;
    logic [TW-1:0]         bin_reg, bin_next;
    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            out_bin_reg, out_bin_next;
    logic [6:0]            out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  wr_anc_en;
    logic                  wr_depth_en;
    logic                  rd_en;
    logic [5:0]            rd_leaf_in;
    logic [5:0]            rd_leaf;
    logic                  rd_oor;
    logic [MAX_TIERS-2:0][6:0] rd_row;
    logic [3:0]            rd_depth;
    logic                  mask_bit;
    logic [6:0]            cnt_head;
    logic [6:0]            pair_value;
    logic [LW:0]           n_eff;
    logic [TW-1:0]         t_eff;
    bins_ctrl_t            ctrl;

    always_comb
    begin
        if (leaf_count_reg == 7'd0)
        begin
            n_eff = (LW + 1)'(1);
        end
        else if (int'(leaf_count_reg) > MAX_LEAVES)
        begin
            n_eff = (LW + 1)'(MAX_LEAVES);
        end
        else
        begin
            n_eff = (LW + 1)'(leaf_count_reg);
        end
        if (num_tiers_reg == 4'd0)
        begin
            t_eff = TW'(1);
        end
        else if (int'(num_tiers_reg) > MAX_TIERS)
        begin
            t_eff = TW'(MAX_TIERS);
        end
        else
        begin
            t_eff = TW'(num_tiers_reg);
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign wr_anc_en   = accept && (mode_t'(mode) == MODE_WR_ANC);
    assign wr_depth_en = accept && (mode_t'(mode) == MODE_WR_DEPTH);
    assign mask_bit    = mask_reg[LW'(rd_leaf)];

    always_comb
    begin
        state_next     = state_reg;
        hist_next      = hist_reg;
        other_next     = other_reg;
        mask_next      = mask_reg;
        issue_k_next   = issue_k_reg;
        bin_next       = bin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bin_next   = out_bin_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_leaf_in     = leaf;
        ctrl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && ((mode_t'(mode) == MODE_PAIR) || (mode_t'(mode) == MODE_HIST)))
                begin
                    rd_en      = 1'b1;
                    rd_leaf_in = leaf;
                    hist_next  = (mode_t'(mode) == MODE_HIST);
                    other_next = other_leaf;
                    mask_next  = prior_mask[MAX_LEAVES-1:0];
                    state_next = S_CAPZ;
                end
            end
            S_CAPZ:
            begin
                ctrl.capture_z = 1'b1;
                ctrl.clear     = 1'b1;
                rd_en          = 1'b1;
                if (hist_reg)
                begin
                    rd_leaf_in   = 6'd0;
                    issue_k_next = (LW + 1)'(1);
                    state_next   = S_WALK;
                end
                else
                begin
                    rd_leaf_in = other_reg;
                    state_next = S_PAIR;
                end
            end
            S_WALK:
            begin
                ctrl.count = 1'b1;
                if (issue_k_reg < n_eff)
                begin
                    rd_en        = 1'b1;
                    rd_leaf_in   = 6'(issue_k_reg);
                    issue_k_next = issue_k_reg + (LW + 1)'(1);
                end
                else
                begin
                    bin_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_PAIR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bin_next   = 4'd0;
                    out_value_next = pair_value;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.shift     = 1'b1;
                    out_valid_next = 1'b1;
                    out_bin_next   = 4'(bin_reg);
                    out_value_next = cnt_head;
                    out_last_next  = (bin_reg == t_eff);
                    bin_next       = bin_reg + TW'(1);
                    if (bin_reg == t_eff)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            leaf_count_reg <= 7'd64;
            num_tiers_reg  <= 4'd8;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en && (cfg_index == CFG_NUM_LEAVES))
            begin
                leaf_count_reg <= cfg_data;
            end
            if (cfg_write_en && (cfg_index == CFG_NUM_TIERS))
            begin
                num_tiers_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg      <= hist_next;
        other_reg     <= other_next;
        mask_reg      <= mask_next;
        issue_k_reg   <= issue_k_next;
        bin_reg       <= bin_next;
        out_bin_reg   <= out_bin_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign bin       = out_bin_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

    hdd_table #(
        .MAX_LEAVES (MAX_LEAVES),
        .MAX_TIERS  (MAX_TIERS)
    ) u_table (
        .clk         (clk),
        .wr_anc_en   (wr_anc_en),
        .wr_depth_en (wr_depth_en),
        .wr_leaf     (leaf),
        .wr_tier     (tier),
        .wr_ancestor (ancestor),
        .wr_depth    (depth),
        .rd_en       (rd_en),
        .rd_leaf_in  (rd_leaf_in),
        .rd_leaf     (rd_leaf),
        .rd_oor      (rd_oor),
        .rd_row      (rd_row),
        .rd_depth    (rd_depth)
    );

    hdd_bins #(
        .MAX_TIERS (MAX_TIERS)
    ) u_bins (
        .clk        (clk),
        .ctrl       (ctrl),
        .t          (t_eff),
        .rd_leaf    (rd_leaf),
        .rd_oor     (rd_oor),
        .rd_row     (rd_row),
        .rd_depth   (rd_depth),
        .mask_bit   (mask_bit),
        .cnt_head   (cnt_head),
        .pair_value (pair_value)
    );

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode[1]) |=> !in_ready)
        else $error("request accepted in the cycle after a query");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode[1]) |=> in_ready)
        else $error("write request left the sequencer busy");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> ((issue_k_reg != '0) && (issue_k_reg <= n_eff)))
        else $error("walk counter outside the leaf range");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (state_reg == S_EMIT)) |-> (int'(bin) <= int'(t_eff)))
        else $error("histogram bin beyond the tier count");

endmodule
